// File: sv/srl_pkg.sv
// package: widths, policy, operation and state codes, lfsr constants for the segment list
`timescale 1ns / 1ps
`default_nettype none
package srl_pkg;
    localparam int SEGMENTS_DEF = 64;
    localparam int SEG_W = 6;
    localparam int CNT_W = 7;
    localparam logic [31:0] LFSR_SEED = 32'd921;
    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

    typedef enum logic [2:0] {
        POL_FIFO = 3'd0,
        POL_LIFO = 3'd1,
        POL_LRU = 3'd2,
        POL_RANDOM = 3'd3,
        POL_READ_MID = 3'd4,
        POL_WRITE_MID = 3'd5,
        POL_RSV6 = 3'd6,
        POL_RSV7 = 3'd7
    } t_policy;

    typedef enum logic [1:0] {
        OP_NOTIFY = 2'd0,
        OP_MODIFY = 2'd1,
        OP_EVICT = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_REMOVE,
        ST_RND,
        ST_INSERT,
        ST_DONE
    } t_state;
endpackage
`default_nettype wire

// File: sv/srl_if.sv
// valid/ready channel interfaces: request, result and config
`timescale 1ns / 1ps
`default_nettype none
interface srl_req_if;
    logic valid;
    logic ready;
    logic [1:0] operation;
    logic [5:0] segment_id;
    logic write_fault;
    modport source(output valid, operation, segment_id, write_fault, input ready);
    modport sink(input valid, operation, segment_id, write_fault, output ready);
endinterface

interface srl_rsp_if;
    logic valid;
    logic ready;
    logic victim_valid;
    logic [5:0] victim_segment;
    logic [6:0] entries_held;
    modport source(output valid, victim_valid, victim_segment, entries_held, input ready);
    modport sink(input valid, victim_valid, victim_segment, entries_held, output ready);
endinterface

interface srl_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] data;
    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

// File: sv/segment_replacement_list.sv
// segment replacement list: ordered list in ram, sequencer for search/shift
// sequence: notify/modify run a search pass, then a removal shift and an insertion shift
//   as needed (one ram entry a cycle); evict runs the removal shift, and random mode
//   first adds a remainder step over the lfsr word (one dividend bit a cycle)
// throughput: one word at a time, next accepted after the result register empties
// reset: synchronous active low clears list length and residency bits, loads lfsr (921), mode fifo
`timescale 1ns / 1ps
`default_nettype none
module segment_replacement_list #(
    parameter int SEGMENTS = srl_pkg::SEGMENTS_DEF
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    srl_cfg_if.sink cfg,
    srl_req_if.sink req,
    srl_rsp_if.source rsp
);
    import srl_pkg::*;
    localparam int AW = $clog2(SEGMENTS);
    localparam int LW = $clog2(SEGMENTS + 1);

    t_state r_state, n_state;
    t_policy r_mode;
    logic [LW-1:0] r_len;
    logic [SEGMENTS-1:0] r_res;
    logic [31:0] r_lfsr;
    t_op r_op;
    logic [SEG_W-1:0] r_seg;
    logic r_wr;
    logic [LW-1:0] r_idx;       // walk index
    logic [LW-1:0] r_pos;       // target position
    logic [31:0] r_rem;         // dividend shifted out msb first
    logic [LW-1:0] r_mod;       // partial remainder
    logic [4:0] r_cnt;
    logic r_phase;              // read-issued flag for walks
    logic r_shift;              // removal past the victim read
    logic r_vv;
    logic [SEG_W-1:0] r_vs;
    logic r_ov;
    logic [CNT_W-1:0] r_oh;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [SEG_W-1:0] wdata, rdata;

    srl_ram #(.WIDTH(SEG_W), .DEPTH(SEGMENTS)) u_order (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    logic in_range, held, midmode, to_mid, full;
    logic acc_req, skip, found, rm_last;
    t_op req_op;
    logic [SEG_W-1:0] victim;
    logic [LW:0] mod_t;
    logic [LW-1:0] mod_nx;

    assign in_range = ({26'd0, req.segment_id} < 32'(SEGMENTS));
    assign held = r_res[AW'(r_seg)];
    assign midmode = (r_mode == POL_READ_MID) || (r_mode == POL_WRITE_MID);
    assign to_mid = (r_mode == POL_READ_MID) ? !r_wr : r_wr;
    assign full = (r_len == LW'(SEGMENTS));
    assign acc_req = req.valid && req.ready;
    assign req_op = t_op'(req.operation);
    assign skip = (!midmode && r_op == OP_MODIFY) ||
                  (!midmode && r_mode != POL_LRU && held) || (!held && full);
    assign found = r_phase && (rdata == r_seg);
    assign rm_last = r_shift ? ((r_idx + 2'd2) >= r_len) :
                     (r_phase && ((r_idx + 1'b1) >= r_len));
    assign victim = r_shift ? r_vs : rdata;
    assign mod_t = {r_mod, r_rem[31]};
    assign mod_nx = (mod_t >= {1'b0, r_len}) ? LW'(mod_t - {1'b0, r_len}) : LW'(mod_t);

    assign cfg.ready = (r_state == ST_IDLE);
    assign req.ready = (r_state == ST_IDLE) && !r_ov;
    assign rsp.valid = r_ov;
    assign rsp.victim_valid = r_vv;
    assign rsp.victim_segment = r_vs;
    assign rsp.entries_held = r_oh;

    logic [31:0] lfsr_nx;
    assign lfsr_nx = r_lfsr[0] ? ((r_lfsr >> 1) ^ LFSR_MASK) : (r_lfsr >> 1);

    // ram port control
    always_comb begin
        we = 1'b0;
        waddr = AW'(r_idx);
        wdata = rdata;
        raddr = AW'(r_idx);
        unique case (r_state)
            ST_REMOVE: begin
                // read victim, then read one ahead while shifting left
                if (r_shift) begin
                    raddr = AW'(r_idx + 2'd2);
                    we = 1'b1;
                end else if (r_phase) begin
                    raddr = AW'(r_idx + 1'b1);
                end
            end
            ST_INSERT: begin
                if (r_idx == r_pos) begin
                    we = 1'b1;
                    wdata = r_seg;
                end else if (r_phase) begin
                    raddr = AW'(r_idx - 2'd2);
                    we = 1'b1;
                end else begin
                    raddr = AW'(r_idx - 1'b1);
                end
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc_req) begin
                    if (req_op == OP_EVICT) begin
                        if (r_len == '0) n_state = ST_DONE;
                        else if (r_mode == POL_RANDOM) n_state = ST_RND;
                        else n_state = ST_REMOVE;
                    end else if ((req_op == OP_NOTIFY || req_op == OP_MODIFY) && in_range) begin
                        n_state = ST_SEARCH;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SEARCH: begin
                if (skip) n_state = ST_DONE;
                else if (!held) n_state = ST_INSERT;
                else if (found) n_state = ST_REMOVE;
            end
            ST_RND: if (r_cnt == 5'd31) n_state = ST_REMOVE;
            ST_REMOVE: if (rm_last) n_state = (r_op == OP_EVICT) ? ST_DONE : ST_INSERT;
            ST_INSERT: if (r_idx == r_pos) n_state = ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode <= POL_FIFO;
            r_len <= '0;
            r_res <= '0;
            r_lfsr <= LFSR_SEED;
            r_ov <= 1'b0;
            r_phase <= 1'b0;
            r_shift <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg.valid && cfg.ready) r_mode <= t_policy'(cfg.data);
            if (r_state == ST_DONE) r_ov <= 1'b1;
            else if (rsp.valid && rsp.ready) r_ov <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (acc_req) begin
                        r_op <= req_op;
                        r_seg <= req.segment_id;
                        r_wr <= req.write_fault;
                        r_phase <= 1'b0;
                        r_shift <= 1'b0;
                        r_vv <= 1'b0;
                        r_vs <= '0;
                        r_mod <= '0;
                        r_cnt <= '0;
                        if (req_op == OP_EVICT && r_mode == POL_RANDOM) begin
                            r_pos <= '0;
                            r_idx <= '0;
                            if (r_len != '0) begin
                                r_lfsr <= lfsr_nx;
                                r_rem <= lfsr_nx;
                            end
                        end else if (req_op == OP_EVICT && r_mode != POL_LIFO &&
                                     r_mode != POL_WRITE_MID) begin
                            r_pos <= r_len - 1'b1;
                            r_idx <= r_len - 1'b1;
                        end else begin
                            r_pos <= '0;
                            r_idx <= '0;
                        end
                    end
                end
                ST_RND: begin
                    // restoring remainder of the lfsr word by the list length
                    r_mod <= mod_nx;
                    r_rem <= r_rem << 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'd31) begin
                        r_pos <= mod_nx;
                        r_idx <= mod_nx;
                        r_phase <= 1'b0;
                    end
                end
                ST_SEARCH: begin
                    if (!skip && !held) begin
                        r_pos <= (midmode && to_mid) ? (r_len >> 1) : '0;
                        r_idx <= r_len;
                        r_phase <= 1'b0;
                    end else if (!skip && found) begin
                        r_pos <= r_idx - 1'b1;
                        r_idx <= r_idx - 1'b1;
                        r_phase <= 1'b0;
                    end else if (!skip) begin
                        r_phase <= 1'b1;
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_REMOVE: begin
                    if (rm_last) begin
                        r_len <= r_len - 1'b1;
                        r_phase <= 1'b0;
                        r_shift <= 1'b0;
                        if (r_op == OP_EVICT) begin
                            r_vv <= 1'b1;
                            r_vs <= victim;
                            r_res[AW'(victim)] <= 1'b0;
                        end else begin
                            r_res[AW'(r_seg)] <= 1'b0;
                            r_idx <= r_len - 1'b1;
                            r_pos <= (midmode && to_mid) ? ((r_len - 1'b1) >> 1) : '0;
                        end
                    end else if (!r_phase) begin
                        r_phase <= 1'b1;
                    end else if (!r_shift) begin
                        r_vs <= rdata;
                        r_shift <= 1'b1;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_INSERT: begin
                    // shift right from the tail down to pos, then write segment
                    if (r_idx == r_pos) begin
                        r_len <= r_len + 1'b1;
                        r_res[AW'(r_seg)] <= 1'b1;
                        r_phase <= 1'b0;
                    end else if (!r_phase) begin
                        r_phase <= 1'b1;
                    end else begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
                ST_DONE: begin
                    r_vv <= (r_op == OP_EVICT) && r_vv;
                    r_vs <= ((r_op == OP_EVICT) && r_vv) ? r_vs : '0;
                    r_oh <= CNT_W'(r_len);
                end
                default: ;
            endcase
        end
    end

    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(SEGMENTS)) else $error("list length overflow");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ($countones(r_res) == 32'(r_len)))
        else $error("residency bits disagree with length");
    a_novict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp.valid && !rsp.victim_valid) |-> (rsp.victim_segment == 6'd0))
        else $error("victim segment without victim");
endmodule
`default_nettype wire

// File: sv/srl_ram.sv
// generic single-port-write, one-read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module srl_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input wire logic i_clk,
    input wire logic i_we,
    input wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input wire logic [WIDTH-1:0] i_wdata,
    input wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
